// ===== rtl/rsw_pkg.sv =====
// shared types and constants of the row split write address generator
package rsw_pkg;

  localparam int unsigned MaxSegments = 16;
  localparam int unsigned SegW        = $clog2(MaxSegments);

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ROWS_PER_TILE        = 3'd0,
    CFG_OUTPUT_PAGES_PER_ROW = 3'd1,
    CFG_ELEMENT_BYTES        = 3'd2,
    CFG_INPUT_BLOCK_COLS     = 3'd3,
    CFG_OUTPUT_BLOCK_COLS    = 3'd4,
    CFG_UNPADDED_COLS        = 3'd5,
    CFG_FIRST_PAGE_INDEX     = 3'd6,
    CFG_FIRST_PAGE_COLS_DONE = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [5:0]  rows_per_tile;
    logic [15:0] output_pages_per_row;
    logic [3:0]  element_bytes;
    logic [12:0] input_block_cols;
    logic [12:0] output_block_cols;
    logic [12:0] unpadded_cols;
    logic [15:0] first_page_index;
    logic [11:0] first_page_cols_done;
  } cfg_t;

  typedef struct packed {
    logic [31:0] read_base;
    logic [15:0] block_index;
    logic [4:0]  row_in_tile;
  } in_t;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] page_id;
    logic [14:0] page_byte_offset;
    logic [15:0] byte_count;
    logic        last;
    logic        truncated;
  } out_t;

  // per-row context handed from the arithmetic pipeline to the emitter
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] page;
    logic [12:0] left;
    logic [12:0] room;
    logic [14:0] offset;
  } row_t;

endpackage

// ===== rtl/rsw_row_pipe.sv =====
// four-stage pipeline computing the source address, first page, first segment room and offset of a row
module rsw_row_pipe (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rsw_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rsw_pkg::in_t  in_data_i,
  output logic          row_valid_o,
  input  logic          row_ready_i,
  output rsw_pkg::row_t row_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  // stage 1 payload
  logic [31:0] base1_q;
  logic [4:0]  row1_q;
  logic [17:0] rc1_q;
  logic [21:0] bk1_q;
  // stage 2 payload
  logic [31:0] base2_q;
  logic [21:0] soff2_q;
  logic [22:0] rd2_q;
  // stage 3 payload
  logic [31:0] src3_q;
  logic [31:0] pm3_q;
  // stage 4 payload
  rsw_pkg::row_t row4_q;

  logic [12:0] page_cols;
  logic [12:0] fpcd_ext;
  logic [15:0] off_full;
  logic [38:0] pm_full;

  assign adv4 = !v4_q || row_ready_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  assign page_cols = (cfg_i.output_block_cols == '0) ? 13'd1 : cfg_i.output_block_cols;
  assign fpcd_ext  = {1'b0, cfg_i.first_page_cols_done};
  assign off_full  = 16'(cfg_i.first_page_cols_done * cfg_i.element_bytes);
  assign pm_full   = 39'(rd2_q * cfg_i.output_pages_per_row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      base1_q <= in_data_i.read_base;
      row1_q  <= in_data_i.row_in_tile;
      rc1_q   <= 18'(in_data_i.row_in_tile * cfg_i.input_block_cols);
      bk1_q   <= 22'(in_data_i.block_index * cfg_i.rows_per_tile);
    end
    if (adv2) begin
      base2_q <= base1_q;
      soff2_q <= 22'(rc1_q * cfg_i.element_bytes);
      rd2_q   <= 23'(bk1_q) + 23'(row1_q);
    end
    if (adv3) begin
      src3_q <= base2_q + 32'(soff2_q);
      pm3_q  <= pm_full[31:0];
    end
    if (adv4) begin
      row4_q.src    <= src3_q;
      row4_q.page   <= pm3_q + 32'(cfg_i.first_page_index);
      row4_q.left   <= cfg_i.unpadded_cols;
      // first page already full: first segment is not bounded by the page
      row4_q.room   <= (fpcd_ext < page_cols) ? (page_cols - fpcd_ext)
                                              : cfg_i.unpadded_cols;
      row4_q.offset <= off_full[14:0];
    end
  end

  assign row_valid_o = v4_q;
  assign row_o       = row4_q;

endmodule

// ===== rtl/rsw_seg_emit.sv =====
// splits one row into page segments, one descriptor per cycle while the output is not stalled, into an output register
module rsw_seg_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rsw_pkg::cfg_t cfg_i,
  input  logic          row_valid_i,
  output logic          row_ready_o,
  input  rsw_pkg::row_t row_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rsw_pkg::out_t out_data_o
);

  logic                     busy_q, busy_d;
  logic                     out_valid_q, out_valid_d;
  logic [31:0]              src_q, src_d;
  logic [31:0]              page_q, page_d;
  logic [12:0]              left_q, left_d;
  logic [12:0]              room_q, room_d;
  logic [14:0]              off_q, off_d;
  logic [rsw_pkg::SegW-1:0] seg_q, seg_d;
  rsw_pkg::out_t            out_q;

  logic        emit, load, seg_end;
  logic [12:0] cols, left_n;
  logic [16:0] bytes;

  always_comb begin
    emit    = busy_q && (!out_valid_q || out_ready_i);
    cols    = (left_q < room_q) ? left_q : room_q;
    bytes   = 17'(cols * cfg_i.element_bytes);
    left_n  = left_q - cols;
    seg_end = (left_n == '0) || (seg_q == rsw_pkg::SegW'(rsw_pkg::MaxSegments - 1));
    row_ready_o = !busy_q || (emit && seg_end);
    load    = row_valid_i && row_ready_o;
  end

  always_comb begin
    busy_d = busy_q;
    src_d  = src_q;
    page_d = page_q;
    left_d = left_q;
    room_d = room_q;
    off_d  = off_q;
    seg_d  = seg_q;
    if (emit) begin
      src_d  = src_q + 32'(bytes);
      page_d = page_q + 32'd1;
      left_d = left_n;
      room_d = (cfg_i.output_block_cols == '0) ? 13'd1 : cfg_i.output_block_cols;
      off_d  = '0;
      seg_d  = seg_q + 1'b1;
      if (seg_end) busy_d = 1'b0;
    end
    if (load) begin
      // a row with no valid columns is dropped here
      busy_d = (row_i.left != '0);
      src_d  = row_i.src;
      page_d = row_i.page;
      left_d = row_i.left;
      room_d = row_i.room;
      off_d  = row_i.offset;
      seg_d  = '0;
    end
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      seg_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      seg_q       <= seg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    page_q <= page_d;
    left_q <= left_d;
    room_q <= room_d;
    off_q  <= off_d;
    if (emit) begin
      out_q.source_address   <= src_q;
      out_q.page_id          <= page_q;
      out_q.page_byte_offset <= off_q;
      out_q.byte_count       <= bytes[15:0];
      out_q.last             <= seg_end;
      out_q.truncated        <= seg_end && (left_n != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_trunc_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.truncated |-> out_q.last)
    else $error("truncated flag on a non-final segment");

  a_busy_has_cols: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> left_q != '0)
    else $error("emitter busy with no columns left");

  a_later_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !seg_end |=> busy_q && off_q == '0)
    else $error("later segment does not start at page offset zero");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && seg_q == rsw_pkg::SegW'(rsw_pkg::MaxSegments - 1) |-> seg_end)
    else $error("run exceeds segment cap");

endmodule

// ===== rtl/row_split_write_address_generator.sv =====
// top level: configuration registers, row arithmetic pipeline and segment emitter
//
// Each accepted transaction is one row request; the block answers with a run of
// write descriptors, one per output page the row's unpadded columns touch, capped
// at rsw_pkg::MaxSegments with the truncated flag set on the final descriptor of a
// cut run. A row with zero unpadded columns yields no descriptors. The row first
// passes a four-stage arithmetic pipeline (address and page products), then the
// segment emitter, which writes each descriptor into the output register. The
// emitter sends one descriptor per cycle while the output is not stalled and
// loads the next row on the cycle of the current row's last descriptor.
// Configuration registers are written through a plain write port and
// must only change while no row is in flight.
module row_split_write_address_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rsw_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rsw_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rsw_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rsw_pkg::out_t                   out_data_o
);

  rsw_pkg::cfg_t     cfg_q;
  rsw_pkg::cfg_reg_e cfg_sel;

  logic          row_valid, row_ready;
  rsw_pkg::row_t row;

  assign cfg_sel = rsw_pkg::cfg_reg_e'(cfg_idx_i);

  // configuration registers, low bits of the write data kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_per_tile        <= 6'd32;
      cfg_q.output_pages_per_row <= 16'd1;
      cfg_q.element_bytes        <= 4'd2;
      cfg_q.input_block_cols     <= 13'd32;
      cfg_q.output_block_cols    <= 13'd32;
      cfg_q.unpadded_cols        <= 13'd32;
      cfg_q.first_page_index     <= 16'd0;
      cfg_q.first_page_cols_done <= 12'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_sel)
        rsw_pkg::CFG_ROWS_PER_TILE:        cfg_q.rows_per_tile        <= cfg_wdata_i[5:0];
        rsw_pkg::CFG_OUTPUT_PAGES_PER_ROW: cfg_q.output_pages_per_row <= cfg_wdata_i;
        rsw_pkg::CFG_ELEMENT_BYTES:        cfg_q.element_bytes        <= cfg_wdata_i[3:0];
        rsw_pkg::CFG_INPUT_BLOCK_COLS:     cfg_q.input_block_cols     <= cfg_wdata_i[12:0];
        rsw_pkg::CFG_OUTPUT_BLOCK_COLS:    cfg_q.output_block_cols    <= cfg_wdata_i[12:0];
        rsw_pkg::CFG_UNPADDED_COLS:        cfg_q.unpadded_cols        <= cfg_wdata_i[12:0];
        rsw_pkg::CFG_FIRST_PAGE_INDEX:     cfg_q.first_page_index     <= cfg_wdata_i;
        rsw_pkg::CFG_FIRST_PAGE_COLS_DONE: cfg_q.first_page_cols_done <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // row arithmetic: source address, first page id, first segment room and offset
  rsw_row_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .row_valid_o (row_valid),
    .row_ready_i (row_ready),
    .row_o       (row)
  );

  // segment split and output register
  rsw_seg_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .row_valid_i (row_valid),
    .row_ready_o (row_ready),
    .row_i       (row),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
